// ===== hdl/satp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// satp_pkg
// Types and constants of the service address record parser.
// ----------------------------------------------------------------------------
package satp_pkg;

   typedef enum logic [1:0] {
      PH_HEADER   = 2'd0,
      PH_CONTENT  = 2'd1,
      PH_FINISHED = 2'd2
   } phase_type;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_ADDRESS = 2'd0;
   localparam kind_type KIND_DONE    = 2'd1;
   localparam kind_type KIND_ERROR   = 2'd2;

   // register indexes of the control port
   localparam logic [7:0] CSR_ADDRESS_TYPE = 8'd0;
   localparam logic [7:0] CSR_ENDING_TYPE  = 8'd1;

   localparam logic [7:0] ADDRESS_TYPE_RESET = 8'd1;
   localparam logic [7:0] ENDING_TYPE_RESET  = 8'd254;

   localparam logic [4:0]  HEADER_BYTES    = 5'd5;
   localparam logic [4:0]  IPV4_ADDR_BYTES = 5'd4;
   localparam logic [4:0]  IPV6_ADDR_BYTES = 5'd16;
   localparam logic [4:0]  PORT_BYTES      = 5'd2;
   localparam logic [31:0] IPV4_RECORD_LEN = 32'd6;
   localparam logic [31:0] IPV6_RECORD_LEN = 32'd18;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

// ===== hdl/service_address_tlv_parser.sv =====
// Results: a result word appears on rsp_* in the cycle after the byte that completes it.
// Throughput: one byte word per cycle; the result register lets a new byte in while
// a result is taken in the same cycle, the only stall is a result left untaken.
// Reset: synchronous, active high; parser returns to the header phase with all
// counters cleared and both type code registers at their reset values.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// service_address_tlv_parser
// Parses type-length-value records from a connection's leading bytes and
// reports a service address, the end of the records, or an error.
// ----------------------------------------------------------------------------
module service_address_tlv_parser (
   input  logic                clock,
   input  logic                reset,
   // byte input
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_new_connection,
   input  logic [7:0]          req_data_byte,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output satp_pkg::kind_type  rsp_kind,
   output logic                rsp_is_ipv6,
   output logic [63:0]         rsp_address_high,
   output logic [63:0]         rsp_address_low,
   output logic [15:0]         rsp_port,
   output logic [15:0]         rsp_consumed_bytes,
   // control registers
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_index,
   input  logic [7:0]          csr_data
);
   import satp_pkg::*;

   logic [7:0]  address_type_ff, address_type_in;
   logic [7:0]  ending_type_ff, ending_type_in;

   phase_type   phase_ff, phase_in;
   logic [4:0]  position_ff, position_in;
   logic [7:0]  record_type_ff, record_type_in;
   logic [31:0] length_ff, length_in;
   logic [63:0] addr_high_ff, addr_high_in;
   logic [63:0] addr_low_ff, addr_low_in;
   logic [15:0] port_ff, port_in;
   logic [15:0] count_ff, count_in;

   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic        rsp_ipv6_ff, rsp_ipv6_in;
   logic [63:0] rsp_high_ff, rsp_high_in;
   logic [63:0] rsp_low_ff, rsp_low_in;
   logic [15:0] rsp_port_ff, rsp_port_in;
   logic [15:0] rsp_count_ff, rsp_count_in;

   logic        req_accept;
   logic        emit;
   logic [4:0]  position_inc;
   logic        is_v6;
   logic [4:0]  addr_bytes;

   // a byte word moves when the result register is free or drains now
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // control registers
   always_comb begin
      address_type_in = address_type_ff;
      ending_type_in  = ending_type_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ADDRESS_TYPE: address_type_in = csr_data;
            CSR_ENDING_TYPE:  ending_type_in  = csr_data;
            default: ;
         endcase
      end
   end

   // parser next state and result
   assign position_inc = position_ff + 5'd1;
   assign is_v6        = (length_ff == IPV6_RECORD_LEN);
   assign addr_bytes   = is_v6 ? IPV6_ADDR_BYTES : IPV4_ADDR_BYTES;

   always_comb begin
      phase_in       = phase_ff;
      position_in    = position_ff;
      record_type_in = record_type_ff;
      length_in      = length_ff;
      addr_high_in   = addr_high_ff;
      addr_low_in    = addr_low_ff;
      port_in        = port_ff;
      count_in       = count_ff;
      emit           = 1'b0;
      rsp_kind_in    = KIND_ERROR;
      rsp_ipv6_in    = 1'b0;
      rsp_high_in    = '0;
      rsp_low_in     = '0;
      rsp_port_in    = '0;
      rsp_count_in   = '0;

      if (req_accept) begin
         if (req_new_connection) begin
            phase_in       = PH_HEADER;
            position_in    = '0;
            record_type_in = '0;
            length_in      = '0;
            addr_high_in   = '0;
            addr_low_in    = '0;
            port_in        = '0;
            count_in       = '0;
         end else begin
            if (phase_ff != PH_FINISHED && count_ff != COUNT_MAX) begin
               count_in = count_ff + 16'd1;
            end
            case (phase_ff)
               PH_HEADER: begin
                  if (position_ff == '0) begin
                     record_type_in = req_data_byte;
                     length_in      = '0;
                  end else begin
                     length_in = {length_ff[23:0], req_data_byte};
                  end
                  position_in = position_inc;
                  // type judged once the full header is in
                  if (position_inc == HEADER_BYTES) begin
                     position_in = '0;
                     if (record_type_ff == address_type_ff) begin
                        if (length_in == IPV4_RECORD_LEN || length_in == IPV6_RECORD_LEN) begin
                           addr_high_in = '0;
                           addr_low_in  = '0;
                           port_in      = '0;
                           phase_in     = PH_CONTENT;
                        end else begin
                           phase_in = PH_FINISHED;
                           emit     = 1'b1;
                        end
                     end else begin
                        phase_in = PH_FINISHED;
                        emit     = 1'b1;
                        if (record_type_ff == ending_type_ff) begin
                           rsp_kind_in  = KIND_DONE;
                           rsp_count_in = count_in;
                        end
                     end
                  end
               end
               PH_CONTENT: begin
                  if (position_ff < addr_bytes) begin
                     addr_high_in = {addr_high_ff[55:0], addr_low_ff[63:56]};
                     addr_low_in  = {addr_low_ff[55:0], req_data_byte};
                  end else begin
                     port_in = {port_ff[7:0], req_data_byte};
                  end
                  position_in = position_inc;
                  if (position_inc == addr_bytes + PORT_BYTES) begin
                     position_in = '0;
                     phase_in    = PH_HEADER;
                     emit        = 1'b1;
                     rsp_kind_in = KIND_ADDRESS;
                     rsp_ipv6_in = is_v6;
                     rsp_high_in = addr_high_in;
                     rsp_low_in  = addr_low_in;
                     rsp_port_in = port_in;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // result register valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         address_type_ff <= ADDRESS_TYPE_RESET;
         ending_type_ff  <= ENDING_TYPE_RESET;
         phase_ff        <= PH_HEADER;
         position_ff     <= '0;
         record_type_ff  <= '0;
         length_ff       <= '0;
         addr_high_ff    <= '0;
         addr_low_ff     <= '0;
         port_ff         <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         address_type_ff <= address_type_in;
         ending_type_ff  <= ending_type_in;
         phase_ff        <= phase_in;
         position_ff     <= position_in;
         record_type_ff  <= record_type_in;
         length_ff       <= length_in;
         addr_high_ff    <= addr_high_in;
         addr_low_ff     <= addr_low_in;
         port_ff         <= port_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload, loaded with each new result word
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_ipv6_ff  <= rsp_ipv6_in;
         rsp_high_ff  <= rsp_high_in;
         rsp_low_ff   <= rsp_low_in;
         rsp_port_ff  <= rsp_port_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_is_ipv6        = rsp_ipv6_ff;
   assign rsp_address_high   = rsp_high_ff;
   assign rsp_address_low    = rsp_low_ff;
   assign rsp_port           = rsp_port_ff;
   assign rsp_consumed_bytes = rsp_count_ff;

`ifndef ASSERT_OFF
   // header position never runs past the header
   a_header_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (position_ff < HEADER_BYTES))
      else $error("header position out of range");

   // content position never runs past address plus port
   a_content_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CONTENT) |-> (position_ff < addr_bytes + PORT_BYTES))
      else $error("content position out of range");

   // finished stays finished until a new connection
   a_finished_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FINISHED && !(req_accept && req_new_connection))
      |=> (phase_ff == PH_FINISHED && !$rose(rsp_valid_ff)))
      else $error("finished parser left its state");

   // only an address word carries address fields
   a_clean_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != KIND_ADDRESS)
      |-> (!rsp_ipv6_ff && rsp_high_ff == '0 && rsp_low_ff == '0 && rsp_port_ff == '0))
      else $error("done or error word carries address fields");

   // an IPv4 address has a clear upper half
   a_ipv4_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_ADDRESS && !rsp_ipv6_ff)
      |-> (rsp_high_ff == '0 && rsp_low_ff[63:32] == '0))
      else $error("IPv4 word has upper address bits set");
`endif

endmodule
